// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lsh_pkg.sv =====
`timescale 1ns / 1ps

package lsh_pkg;

    localparam int PIX_W     = 8;
    localparam int ROW_W     = 16;
    localparam int OUT_COL_W = 10;
    localparam int FW_W      = 11;
    localparam int FH_W      = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int SLOT_N    = 4;

    localparam int DEFAULT_MAX_WIDTH = 1024;

    localparam logic [FW_W-1:0] FW_RESET = 11'd640;
    localparam logic [FH_W-1:0] FH_RESET = 16'd480;

    // Weight of the center tap.
    localparam int SHARP_GAIN = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // Result slots of one input, in emission order.
    typedef enum logic [1:0] {
        SLOT_UP_PREV  = 2'd0,   // (r-1, c-1), the filtered pixel
        SLOT_UP_LAST  = 2'd1,   // (r-1, c) at the last column
        SLOT_CUR_PREV = 2'd2,   // (r, c-1) on the last row
        SLOT_CUR_LAST = 2'd3    // (r, c) on the last row, last column
    } slot_t;

    // Results caused by one input, handed to the emit stage.
    typedef struct packed {
        logic [SLOT_N-1:0]    mask;
        logic [PIX_W-1:0]     pix;
        logic [ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0] col;
        logic                 frame_end;
    } lsh_batch_t;

endpackage

// ===== rtl/lsh_emit.sv =====
`timescale 1ns / 1ps

module lsh_emit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          batch_valid,
    input  lsh_pkg::lsh_batch_t           batch,
    output logic                          batch_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lsh_pkg::PIX_W-1:0]     pixel_out,
    output logic [lsh_pkg::ROW_W-1:0]     out_row,
    output logic [lsh_pkg::OUT_COL_W-1:0] out_col,
    output logic                          run_last,
    output logic                          frame_done
);

    import lsh_pkg::*;

    logic [SLOT_N-1:0]    mask_reg;
    logic [SLOT_N-1:0]    mask_next;
    logic [PIX_W-1:0]     pix_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [OUT_COL_W-1:0] col_reg;
    logic                 frame_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [PIX_W-1:0]     pixel_out_reg;
    logic [ROW_W-1:0]     out_row_reg;
    logic [OUT_COL_W-1:0] out_col_reg;
    logic                 run_last_reg;
    logic                 frame_done_reg;

    slot_t                slot;
    logic [SLOT_N-1:0]    slot_bit;
    logic [SLOT_N-1:0]    remaining;
    logic                 out_adv;
    logic                 pop;
    logic                 load;

    // Pick the first pending slot.
    always_comb
    begin
        slot     = SLOT_UP_PREV;
        slot_bit = 4'b0001;
        priority if (mask_reg[0])
        begin
            slot     = SLOT_UP_PREV;
            slot_bit = 4'b0001;
        end
        else if (mask_reg[1])
        begin
            slot     = SLOT_UP_LAST;
            slot_bit = 4'b0010;
        end
        else if (mask_reg[2])
        begin
            slot     = SLOT_CUR_PREV;
            slot_bit = 4'b0100;
        end
        else
        begin
            slot     = SLOT_CUR_LAST;
            slot_bit = 4'b1000;
        end
    end

    assign remaining   = mask_reg & ~slot_bit;
    assign out_adv     = !out_valid_reg || out_ready;
    assign pop         = (mask_reg != '0) && out_adv;
    assign batch_ready = (mask_reg == '0) || (pop && (remaining == '0));
    assign load        = batch_valid && batch_ready;

    always_comb
    begin
        mask_next = mask_reg;
        if (pop)
        begin
            mask_next = remaining;
        end
        if (load)
        begin
            mask_next = batch.mask;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pix_reg   <= batch.pix;
            row_reg   <= batch.row;
            col_reg   <= batch.col;
            frame_reg <= batch.frame_end;
        end
        if (pop)
        begin
            pixel_out_reg  <= (slot == SLOT_UP_PREV) ? pix_reg : '0;
            out_row_reg    <= (slot == SLOT_UP_PREV || slot == SLOT_UP_LAST)
                              ? row_reg - 1'b1 : row_reg;
            out_col_reg    <= (slot == SLOT_UP_PREV || slot == SLOT_CUR_PREV)
                              ? col_reg - 1'b1 : col_reg;
            run_last_reg   <= (remaining == '0);
            frame_done_reg <= (remaining == '0) && frame_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_out  = pixel_out_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign run_last   = run_last_reg;
    assign frame_done = frame_done_reg;

endmodule

// ===== rtl/laplacian_sharpen_3x3.sv =====
`timescale 1ns / 1ps

// 3x3 Laplacian sharpener for a raster pixel stream. Each accepted 8-bit pixel
// beat at (row r, column c) releases the result for (r-1, c-1), plus the
// right-edge pixel at the last column and the bottom-row zeros on the last row,
// so every pixel of the frame leaves exactly once, with its
// row and column attached. Interior results are 5*center minus the four direct
// neighbors, saturated to 0..255; the frame border is zero. run_last marks the
// final result beat of one input, frame_done the final beat of the frame.
// Rate: one pixel beat per clock while out_ready is high and each input causes
// at most one result; results leave one per clock while out_ready is high, so
// an input with two to four results holds off the next until all have left. A
// beat passes stage 1 and the emit stage before the output register. Two line
// buffers of MAX_WIDTH x 8 bits, each one read and one write per clock, hold
// the two rows above; their content is not cleared and there is no start-up
// sweep. frame_width saturates to 3..MAX_WIDTH, frame_height to at least 3;
// write them only while the block is empty.

`include "assert_macros.svh"

module laplacian_sharpen_3x3
#(
    parameter int MAX_WIDTH = lsh_pkg::DEFAULT_MAX_WIDTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lsh_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [lsh_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [lsh_pkg::PIX_W-1:0]     pixel_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lsh_pkg::PIX_W-1:0]     pixel_out,
    output logic [lsh_pkg::ROW_W-1:0]     out_row,
    output logic [lsh_pkg::OUT_COL_W-1:0] out_col,
    output logic                          run_last,
    output logic                          frame_done
);

    import lsh_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;

    // Configuration registers.
    logic [FW_W-1:0] frame_width_reg;
    logic [FH_W-1:0] frame_height_reg;

    // Raster position of the next input beat.
    logic [COL_W-1:0] col_count_reg;
    logic [COL_W-1:0] col_count_next;
    logic [ROW_W-1:0] row_count_reg;
    logic [ROW_W-1:0] row_count_next;

    // Line buffers: prev holds row r-1, prev2 holds row r-2.
    logic [PIX_W-1:0] line_prev_mem  [MAX_WIDTH];
    logic [PIX_W-1:0] line_prev2_mem [MAX_WIDTH];
    logic [PIX_W-1:0] lp_rd_reg;
    logic [PIX_W-1:0] lp2_rd_reg;

    // Window: 0..2 middle row at c-2..c, 3 top at c-1, 4 bottom at c, 5 top at c.
    logic [PIX_W-1:0] win_reg [6];

    // Stage 1: pixel waiting for its line-buffer read data.
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [PIX_W-1:0]  s1_pix_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic [SLOT_N-1:0] s1_mask_reg;
    logic              s1_interior_reg;
    logic              s1_frame_reg;

    logic [COL_W-1:0]  w_last;
    logic [FH_W-1:0]   h_last;
    logic              last_col;
    logic              last_row;
    logic              interior;
    logic [SLOT_N-1:0] slot_mask;

    logic              in_fire;
    logic              s1_adv;
    logic              batch_ready;
    lsh_batch_t        batch;

    logic [10:0]        gain_term;
    logic [9:0]         nb_sum;
    logic signed [11:0] diff;
    logic [PIX_W-1:0]   sharp_pix;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FW_RESET;
            frame_height_reg <= FH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[FH_W-1:0];
                default:          ;
            endcase
        end
    end

    // Last column and row indexes after saturating the frame size.
    always_comb
    begin
        priority if (frame_width_reg < 11'd3)
        begin
            w_last = COL_W'(2);
        end
        else if (32'(frame_width_reg) > MAX_WIDTH)
        begin
            w_last = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            w_last = COL_W'(frame_width_reg - 11'd1);
        end
    end

    assign h_last = (frame_height_reg < 16'd3) ? 16'd2 : frame_height_reg - 16'd1;

    // ---------------------------------------------------------------- stage 0
    assign last_col = col_count_reg >= w_last;
    assign last_row = row_count_reg >= h_last;

    // Output (r-1, c-1) is filtered only when it lies off the border.
    assign interior = (row_count_reg >= 16'd2) && (row_count_reg <= h_last)
                   && (col_count_reg >= COL_W'(2)) && (col_count_reg <= w_last);

    assign slot_mask[SLOT_UP_PREV]  = (row_count_reg != '0) && (col_count_reg != '0);
    assign slot_mask[SLOT_UP_LAST]  = (row_count_reg != '0) && last_col;
    assign slot_mask[SLOT_CUR_PREV] = last_row && (col_count_reg != '0);
    assign slot_mask[SLOT_CUR_LAST] = last_row && last_col;

    assign s1_adv   = s1_valid_reg && batch_ready;
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_fire  = in_valid && in_ready;

    // Advance the raster position; wrap to a new frame after the last pixel.
    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (in_fire)
        begin
            if (last_col)
            begin
                col_count_next = '0;
                row_count_next = last_row ? '0 : row_count_reg + 16'd1;
            end
            else
            begin
                col_count_next = col_count_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            s1_valid_reg  <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pix_reg      <= pixel_in;
            s1_col_reg      <= col_count_reg;
            s1_row_reg      <= row_count_reg;
            s1_mask_reg     <= slot_mask;
            s1_interior_reg <= interior;
            s1_frame_reg    <= last_row && last_col;
        end
    end

    // Row r-1 buffer: read the old entry and drop the new pixel in its place.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            lp_rd_reg                     <= line_prev_mem[col_count_reg];
            line_prev_mem[col_count_reg]  <= pixel_in;
        end
    end

    // Row r-2 buffer: read at accept, write back the displaced r-1 entry when
    // stage 1 moves on. Successive columns never share an entry, and an entry
    // comes back only after at least three beats, so no forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            lp2_rd_reg <= line_prev2_mem[col_count_reg];
        end
        if (s1_adv)
        begin
            line_prev2_mem[s1_col_reg] <= lp_rd_reg;
        end
    end

    // ---------------------------------------------------------------- stage 1
    // Taps after the shift: center = win[2], left = win[1], right = new read,
    // up = win[5], down = win[4] (the previous pixel of the current row).
    assign gain_term = 11'(SHARP_GAIN) * {3'b000, win_reg[2]};
    assign nb_sum    = 10'(win_reg[1]) + 10'(lp_rd_reg) + 10'(win_reg[5]) + 10'(win_reg[4]);
    assign diff      = $signed({1'b0, gain_term}) - $signed({2'b00, nb_sum});

    always_comb
    begin
        priority if (diff < 12'sd0)
        begin
            sharp_pix = '0;
        end
        else if (diff > 12'sd255)
        begin
            sharp_pix = '1;
        end
        else
        begin
            sharp_pix = diff[PIX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_adv)
        begin
            win_reg[3] <= win_reg[5];
            win_reg[5] <= lp2_rd_reg;
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= lp_rd_reg;
            win_reg[4] <= s1_pix_reg;
        end
    end

    assign batch.mask      = s1_mask_reg;
    assign batch.pix       = s1_interior_reg ? sharp_pix : '0;
    assign batch.row       = s1_row_reg;
    assign batch.col       = OUT_COL_W'(s1_col_reg);
    assign batch.frame_end = s1_frame_reg;

    // ---------------------------------------------------------------- emit
    lsh_emit u_emit
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .batch_valid (s1_valid_reg),
        .batch       (batch),
        .batch_ready (batch_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_out   (pixel_out),
        .out_row     (out_row),
        .out_col     (out_col),
        .run_last    (run_last),
        .frame_done  (frame_done)
    );

    // ---------------------------------------------------------------- checks
    // The row r-2 write-back and the next read never hit the same entry.
    `ASSERT_SAME(a_lb_no_collide, s1_adv && in_fire, s1_col_reg != col_count_reg,
        "line buffer write and read collide")
    // The frame's last pixel wraps the raster position to the origin.
    `ASSERT_NEXT(a_frame_wrap, in_fire && last_row && last_col,
        row_count_reg == '0 && col_count_reg == '0, "raster position did not wrap")
    // The end of a frame is always the end of its input's run.
    `ASSERT_SAME(a_done_is_last, out_valid && frame_done, run_last,
        "frame_done without run_last")

endmodule

// ===== verif/laplacian_sharpen_3x3_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for laplacian_sharpen_3x3.
//
// Pixel beats go in on the in_valid/in_ready channel, result beats come back
// on out_valid/out_ready. A scoreboard object keeps its own copy of the line
// buffers, the 3x3 window and the row/column counters. For every accepted
// pixel it predicts the zero to four result beats it releases, and checks
// every accepted result beat against the oldest prediction.

module laplacian_sharpen_3x3_tb;

    import lsh_pkg::*;

    localparam int MAX_W        = DEFAULT_MAX_WIDTH;
    localparam int DRAIN_CYCLES = 8;             // extra wait after the last predicted beat
    localparam int HOLD_CYCLES  = 80;            // long receiver stall, fills the block
    localparam int RAND_PIXELS  = 30;
    localparam longint TIMEOUT_NS = 64'd10_000_000;

    // One result beat as it leaves the block.
    typedef struct {
        logic [PIX_W-1:0]     pix;
        logic [ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0] col;
        logic                 is_last;
        logic                 is_done;
    } sharp_beat_t;

    // Predicts the sharpened stream and checks what the block sends back.
    class sharpen_scoreboard;
        logic [FW_W-1:0]  width_reg;
        logic [FH_W-1:0]  height_reg;
        logic [PIX_W-1:0] line_up  [MAX_W];      // row r-1
        logic [PIX_W-1:0] line_up2 [MAX_W];      // row r-2
        // 0,1,2: row r-1 at c-2,c-1,c; 3: row r-2 at c-1; 4: row r at c; 5: row r-2 at c
        logic [PIX_W-1:0] win [6];
        int unsigned      row_cnt;
        int unsigned      col_cnt;
        sharp_beat_t      beat_q [$];
        sharp_beat_t      batch [$];
        int unsigned      mismatches;

        function new();
            width_reg  = FW_RESET;
            height_reg = FH_RESET;
            foreach (line_up[i]) begin
                line_up[i]  = '0;
                line_up2[i] = '0;
            end
            foreach (win[i])
                win[i] = '0;
            row_cnt    = 0;
            col_cnt    = 0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == REG_FRAME_WIDTH)
                width_reg = data[FW_W-1:0];
            else if (idx == REG_FRAME_HEIGHT)
                height_reg = data[FH_W-1:0];
        endfunction

        function bit at_frame_start();
            return row_cnt == 0 && col_cnt == 0;
        endfunction

        function int unsigned pending();
            return beat_q.size();
        endfunction

        function void stage(logic [PIX_W-1:0] pix, int unsigned row, int unsigned col);
            sharp_beat_t b;
            b.pix     = pix;
            b.row     = row[ROW_W-1:0];
            b.col     = col[OUT_COL_W-1:0];
            b.is_last = 1'b0;
            b.is_done = 1'b0;
            batch = {batch, b};
        endfunction

        // Advance the predicted block by one accepted pixel beat.
        function void note_pixel(logic [PIX_W-1:0] p);
            int unsigned      w, h, r, c, orow, ocol;
            int               v;
            bit               lc, lr;
            logic [PIX_W-1:0] below, val;
            w = width_reg;
            if (w < 3) w = 3;
            if (w > MAX_W) w = MAX_W;
            h = height_reg;
            if (h < 3) h = 3;
            r = row_cnt;
            c = col_cnt;
            if (c >= MAX_W) c = MAX_W - 1;
            lc = (c >= w - 1);
            lr = (r >= h - 1);

            win[3] = win[5];
            win[5] = line_up2[c];
            win[0] = win[1];
            win[1] = win[2];
            win[2] = line_up[c];
            below  = win[4];
            win[4] = p;

            batch.delete();
            if (r >= 1 && c >= 1) begin
                orow = r - 1;
                ocol = c - 1;
                val  = '0;
                if (orow != 0 && orow < h - 1 && ocol != 0 && ocol < w - 1) begin
                    v = SHARP_GAIN * int'(win[1]) - int'(win[0]) - int'(win[2])
                        - int'(win[3]) - int'(below);
                    if (v < 0) v = 0;
                    if (v > 255) v = 255;
                    val = v[PIX_W-1:0];
                end
                stage(val, orow, ocol);
            end
            if (r >= 1 && lc)
                stage('0, r - 1, c);
            if (lr) begin
                if (c >= 1)
                    stage('0, r, c - 1);
                if (lc)
                    stage('0, r, c);
            end
            if (batch.size() > 0) begin
                batch[batch.size() - 1].is_last = 1'b1;
                if (lr && lc)
                    batch[batch.size() - 1].is_done = 1'b1;
            end
            foreach (batch[i])
                beat_q = {beat_q, batch[i]};

            line_up2[c] = line_up[c];
            line_up[c]  = p;

            if (lc) begin
                col_cnt = 0;
                row_cnt = lr ? 0 : ((r + 1) & 32'hFFFF);
            end
            else begin
                col_cnt = c + 1;
            end
        endfunction

        function void check_result(sharp_beat_t got);
            sharp_beat_t want;
            if (beat_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: pix %0d row %0d col %0d %s %0b %s %0b",
                             got.pix, got.row, got.col, "last", got.is_last,
                             "done", got.is_done);
                return;
            end
            want = beat_q.pop_front();
            if (got.pix !== want.pix || got.row !== want.row || got.col !== want.col
                || got.is_last !== want.is_last || got.is_done !== want.is_done) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("mismatch: expected pix %0d row %0d col %0d last %0b done %0b,",
                           want.pix, want.row, want.col, want.is_last, want.is_done);
                    $display(" got pix %0d row %0d col %0d last %0b done %0b",
                             got.pix, got.row, got.col, got.is_last, got.is_done);
                end
            end
        endfunction
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [PIX_W-1:0]     pixel_in  = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [PIX_W-1:0]     pixel_out;
    logic [ROW_W-1:0]     out_row;
    logic [OUT_COL_W-1:0] out_col;
    logic                 run_last;
    logic                 frame_done;

    sharpen_scoreboard sb = new();

    int unsigned px_sent       = 0;
    bit          sender_burst  = 1'b0;   // no gaps between pixel beats while set
    bit          hold_off_req  = 1'b0;   // ask the result side for one long stall
    bit          hold_off_done = 1'b0;

    laplacian_sharpen_3x3 dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel_in   (pixel_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_out  (pixel_out),
        .out_row    (out_row),
        .out_col    (out_col),
        .run_last   (run_last),
        .frame_done (frame_done)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one pixel beat and hold it until the block takes it. Valid is only
    // dropped when a gap is drawn, so back-to-back beats keep valid high.
    task automatic send_pixel(input logic [PIX_W-1:0] p);
        int unsigned gap;
        gap = sender_burst ? 0 : $urandom_range(0, 5);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        pixel_in <= p;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_pixel(p);
        px_sent++;
    endtask

    // Bias toward the rails so the clamp is hit from both sides.
    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Send pixels until the predicted counters wrap back to row 0, column 0.
    task automatic send_frame();
        do
            send_pixel(rand_pixel());
        while (!sb.at_frame_start());
    endtask

    // Drop valid, drain every predicted beat, then let the pipeline empty out.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // Result side: draw a stall per beat, with calm stretches and one long
    // hold-off while the sender keeps pushing pixels.
    initial
    begin : result_sink
        int unsigned wait_cyc;
        int unsigned calm_left;
        sharp_beat_t got;
        calm_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !hold_off_done)
            begin
                wait_cyc      = HOLD_CYCLES;
                hold_off_done = 1'b1;
            end
            else if (calm_left > 0)
            begin
                wait_cyc = 0;
                calm_left--;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                calm_left = $urandom_range(10, 30);
                wait_cyc  = 0;
            end
            else
            begin
                wait_cyc = $urandom_range(0, 5);
            end
            if (wait_cyc > 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_cyc) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            got.pix     = pixel_out;
            got.row     = out_row;
            got.col     = out_col;
            got.is_last = run_last;
            got.is_done = frame_done;
            sb.check_result(got);
        end
    end

    initial
    begin : stimulus
        // Checkerboard: interior centers of 0 clamp low, centers of 255 clamp high.
        logic [PIX_W-1:0] checker_px [16] = '{
            8'd0,   8'd255, 8'd0,   8'd255,
            8'd255, 8'd0,   8'd255, 8'd0,
            8'd0,   8'd255, 8'd0,   8'd255,
            8'd255, 8'd0,   8'd255, 8'd0
        };
        // Smallest frame: one interior pixel, 5*100 - 260 = 240 with no clamp.
        logic [PIX_W-1:0] tiny_px [9] = '{
            8'd255, 8'd80,  8'd1,
            8'd50,  8'd100, 8'd60,
            8'd254, 8'd70,  8'd0
        };
        int unsigned rand_start;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: 4x4 checkerboard.
        write_reg(REG_FRAME_WIDTH, 16'd4);
        write_reg(REG_FRAME_HEIGHT, 16'd4);
        foreach (checker_px[i])
            send_pixel(checker_px[i]);

        // Directed: width and height below range, both saturate to 3.
        settle();
        write_reg(REG_FRAME_WIDTH, 16'd0);
        write_reg(REG_FRAME_HEIGHT, 16'd2);
        foreach (tiny_px[i])
            send_pixel(tiny_px[i]);

        // Back-to-back pixels while the result side stalls for a long stretch.
        settle();
        write_reg(REG_FRAME_WIDTH, 16'd12);
        write_reg(REG_FRAME_HEIGHT, 16'd6);
        sender_burst = 1'b1;
        hold_off_req = 1'b1;
        send_frame();
        sender_burst = 1'b0;

        // Random small frames, some with out-of-range sizes.
        rand_start = px_sent;
        while (px_sent - rand_start < RAND_PIXELS)
        begin
            settle();
            write_reg(REG_FRAME_WIDTH, CFG_W'(($urandom_range(0, 5) == 0)
                      ? $urandom_range(0, 2) : $urandom_range(3, 12)));
            write_reg(REG_FRAME_HEIGHT, CFG_W'(($urandom_range(0, 5) == 0)
                      ? $urandom_range(0, 2) : $urandom_range(3, 6)));
            repeat ($urandom_range(1, 2))
            begin
                sender_burst = ($urandom_range(0, 3) == 0);
                send_frame();
            end
        end
        sender_burst = 1'b0;

        // Height cut mid-frame: tallest height, five rows in, then drop to 3 so
        // the current row becomes the last one.
        settle();
        write_reg(REG_FRAME_WIDTH, 16'd3);
        write_reg(REG_FRAME_HEIGHT, 16'hFFFF);
        repeat (15)
            send_pixel(rand_pixel());
        settle();
        write_reg(REG_FRAME_HEIGHT, 16'd3);
        send_frame();

        // Width cut mid-row: column 6 of width 8 turns into the last column of width 4.
        settle();
        write_reg(REG_FRAME_WIDTH, 16'd8);
        write_reg(REG_FRAME_HEIGHT, 16'd4);
        repeat (22)
            send_pixel(rand_pixel());
        settle();
        write_reg(REG_FRAME_WIDTH, 16'd4);
        send_frame();

        // Over-wide write saturates to the buffer depth; twenty pixels in, cut
        // the width to 5 so column 20 becomes the last column of row 0.
        settle();
        write_reg(REG_FRAME_WIDTH, 16'hFFFF);
        write_reg(REG_FRAME_HEIGHT, 16'd3);
        repeat (20)
            send_pixel(rand_pixel());
        settle();
        write_reg(REG_FRAME_WIDTH, 16'd5);
        send_frame();

        settle();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
